[rtl/core/pcq_pkg.sv]
package pcq_pkg;

  localparam int unsigned LenW = 4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_NOTE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    status_e             status;
    logic [LenW-1:0]     len;
  } cmd_ctrl_t;

endpackage

[rtl/core/pcq_front.sv]
module pcq_front #(
  parameter int unsigned NUM_CLASSES = 32,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned CLS_W       = 5,
  parameter int unsigned SLOT_W      = 3,
  parameter int unsigned CNT_W       = 4,
  parameter int unsigned ST_W        = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [4:0]         class_index_i,
  input  logic [15:0]        item_tag_i,
  input  logic               urgent_i,
  output logic               cmd_valid_o,
  input  logic               cmd_full_i,
  output pcq_pkg::cmd_ctrl_t cmd_ctrl_o,
  output logic [CLS_W-1:0]   cmd_cls_o,
  output logic [SLOT_W-1:0]  cmd_slot_o,
  output logic [ST_W-1:0]    cmd_tag_o,
  output logic               cmd_urgent_o
);
  import pcq_pkg::*;

  localparam int unsigned SumW = CNT_W + 1;

  logic [CNT_W-1:0]  cnt_q  [NUM_CLASSES];
  logic [SLOT_W-1:0] head_q [NUM_CLASSES];
  logic [CNT_W-1:0]  cnt_d;
  logic [SLOT_W-1:0] head_d;
  logic              upd;
  logic              accept;
  logic [6:0]        cls_ext;
  logic              in_range;
  logic [CLS_W-1:0]  idx;
  logic [CNT_W-1:0]  cnt;
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] head_dec;
  logic [SLOT_W-1:0] head_inc;
  logic [SumW-1:0]   tail_sum;
  logic [SLOT_W-1:0] tail;
  logic [7:0]        len_add;
  logic [7:0]        len_cur;
  logic [7:0]        len_pick;

  assign in_stall_o  = cmd_full_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i & ~cmd_full_i;

  assign cls_ext  = {2'b00, class_index_i};
  assign in_range = cls_ext < 7'(NUM_CLASSES);
  assign idx      = cls_ext[CLS_W-1:0];
  assign cnt      = cnt_q[idx];
  assign head     = head_q[idx];

  assign head_dec = (head == '0) ? SLOT_W'(QUEUE_DEPTH - 1) : head - SLOT_W'(1);
  assign head_inc = (head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head + SLOT_W'(1);

  always_comb begin
    tail_sum = SumW'(head) + SumW'(cnt);
    if (tail_sum >= SumW'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SumW'(QUEUE_DEPTH);
    end
  end
  assign tail = tail_sum[SLOT_W-1:0];

  assign len_cur  = 8'(cnt);
  assign len_add  = 8'(cnt) + 8'd1;
  assign len_pick = 8'(cnt) - 8'd1;

  assign cmd_cls_o    = idx;
  assign cmd_tag_o    = item_tag_i[ST_W-1:0];
  assign cmd_urgent_o = urgent_i;

  always_comb begin
    cmd_ctrl_o.kind   = CMD_NOTE;
    cmd_ctrl_o.status = ST_OK;
    cmd_ctrl_o.len    = '0;
    cmd_slot_o        = head;
    cnt_d             = cnt;
    head_d            = head;
    upd               = 1'b0;
    if (!in_range) begin
      cmd_ctrl_o.status = ST_RANGE;
    end else if (!op_i) begin
      if (cnt == CNT_W'(QUEUE_DEPTH)) begin
        cmd_ctrl_o.status = ST_FULL;
        cmd_ctrl_o.len    = len_cur[LenW-1:0];
      end else begin
        cmd_ctrl_o.kind = CMD_WRITE;
        cmd_ctrl_o.len  = len_add[LenW-1:0];
        cnt_d           = cnt + CNT_W'(1);
        upd             = 1'b1;
        if (urgent_i) begin
          cmd_slot_o = head_dec;
          head_d     = head_dec;
        end else begin
          cmd_slot_o = tail;
        end
      end
    end else begin
      if (cnt == '0) begin
        cmd_ctrl_o.status = ST_EMPTY;
      end else begin
        cmd_ctrl_o.kind = CMD_READ;
        cmd_ctrl_o.len  = len_pick[LenW-1:0];
        cnt_d           = cnt - CNT_W'(1);
        head_d          = head_inc;
        upd             = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
      end
    end else if (accept && upd) begin
      cnt_q[idx]  <= cnt_d;
      head_q[idx] <= head_d;
    end
  end

endmodule

[rtl/core/pcq_cmd_fifo.sv]
module pcq_cmd_fifo #(
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              full_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  logic [DATA_W-1:0] entry_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        cnt_q;
  logic [1:0]        cnt_d;
  logic              push;
  logic              pop;

  assign full_o      = cnt_q == 2'd2;
  assign pop_valid_o = cnt_q != 2'd0;
  assign pop_data_o  = entry_q[rd_ptr_q];
  assign push        = push_valid_i & ~full_o;
  assign pop         = pop_valid_o & pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/pcq_back.sv]
module pcq_back #(
  parameter int unsigned NUM_CLASSES = 32,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned CLS_W       = 5,
  parameter int unsigned SLOT_W      = 3,
  parameter int unsigned ST_W        = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  pcq_pkg::cmd_ctrl_t cmd_ctrl_i,
  input  logic [CLS_W-1:0]   cmd_cls_i,
  input  logic [SLOT_W-1:0]  cmd_slot_i,
  input  logic [ST_W-1:0]    cmd_tag_i,
  input  logic               cmd_urgent_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [15:0]        picked_tag_o,
  output logic               picked_urgent_o,
  output logic [3:0]         queue_length_o
);
  import pcq_pkg::*;

  logic [ST_W:0]  mem_q [NUM_CLASSES][QUEUE_DEPTH];
  logic [ST_W:0]  rd_q;
  logic           pop;
  logic           s1_adv;
  logic           s1_valid_q;
  logic           s1_valid_d;
  cmd_ctrl_t      s1_ctrl_q;
  logic           out_valid_q;
  logic [1:0]     status_q;
  logic [15:0]    tag_q;
  logic           urg_q;
  logic [3:0]     len_q;

  assign s1_adv      = ~out_valid_q | ~out_stall_i;
  assign cmd_ready_o = ~s1_valid_q | s1_adv;
  assign pop         = cmd_valid_i & cmd_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && cmd_ctrl_i.kind == CMD_WRITE) begin
      mem_q[cmd_cls_i][cmd_slot_i] <= {cmd_urgent_i, cmd_tag_i};
    end
    if (pop && cmd_ctrl_i.kind == CMD_READ) begin
      rd_q <= mem_q[cmd_cls_i][cmd_slot_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_ctrl_q <= cmd_ctrl_i;
    end
    if (s1_adv && s1_valid_q) begin
      status_q <= s1_ctrl_q.status;
      len_q    <= s1_ctrl_q.len;
      case (s1_ctrl_q.kind)
        CMD_READ: begin
          tag_q <= 16'(rd_q[ST_W-1:0]);
          urg_q <= rd_q[ST_W];
        end
        default: begin
          tag_q <= '0;
          urg_q <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign picked_tag_o    = tag_q;
  assign picked_urgent_o = urg_q;
  assign queue_length_o  = len_q;

endmodule

[rtl/core/per_class_queue_urgent_front.sv]
// channel  valid       stall        payload
// in       in_valid_i  in_stall_o   op_i, class_index_i, item_tag_i, urgent_i
// out      out_valid_o out_stall_i  status_o, picked_tag_o, picked_urgent_o, queue_length_o
//
// One item per cycle while out_stall_i is low; results pass the command queue first.
// Front resolves count/head per class on acceptance; back does the single
// storage write or registered read, then the output register.
// Reset clears counts, head positions, queue and valid flags; storage is not cleared.
// in_stall_o rises only when the two-entry command queue is full.
module per_class_queue_urgent_front #(
  parameter int unsigned NUM_CLASSES = 32,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned TAG_WIDTH   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [4:0]  class_index_i,
  input  logic [15:0] item_tag_i,
  input  logic        urgent_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] picked_tag_o,
  output logic        picked_urgent_o,
  output logic [3:0]  queue_length_o
);
  import pcq_pkg::*;

  localparam int unsigned ClsW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned SlotW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned StW    = (TAG_WIDTH < 16) ? TAG_WIDTH : 16;
  localparam int unsigned CtrlW  = $bits(cmd_ctrl_t);
  localparam int unsigned FifoW  = CtrlW + ClsW + SlotW + StW + 1;

  logic              f_valid;
  logic              f_full;
  cmd_ctrl_t         f_ctrl;
  logic [ClsW-1:0]   f_cls;
  logic [SlotW-1:0]  f_slot;
  logic [StW-1:0]    f_tag;
  logic              f_urg;
  logic [FifoW-1:0]  push_data;
  logic [FifoW-1:0]  pop_data;
  logic              b_valid;
  logic              b_ready;
  cmd_ctrl_t         b_ctrl;

  pcq_front #(
    .NUM_CLASSES (NUM_CLASSES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CLS_W       (ClsW),
    .SLOT_W      (SlotW),
    .CNT_W       (CntW),
    .ST_W        (StW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .class_index_i (class_index_i),
    .item_tag_i    (item_tag_i),
    .urgent_i      (urgent_i),
    .cmd_valid_o   (f_valid),
    .cmd_full_i    (f_full),
    .cmd_ctrl_o    (f_ctrl),
    .cmd_cls_o     (f_cls),
    .cmd_slot_o    (f_slot),
    .cmd_tag_o     (f_tag),
    .cmd_urgent_o  (f_urg)
  );

  assign push_data = {f_ctrl, f_cls, f_slot, f_tag, f_urg};

  pcq_cmd_fifo #(
    .DATA_W (FifoW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .full_o       (f_full),
    .push_data_i  (push_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (pop_data)
  );

  assign b_ctrl = cmd_ctrl_t'(pop_data[FifoW-1 -: CtrlW]);

  pcq_back #(
    .NUM_CLASSES (NUM_CLASSES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CLS_W       (ClsW),
    .SLOT_W      (SlotW),
    .ST_W        (StW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (b_valid),
    .cmd_ready_o     (b_ready),
    .cmd_ctrl_i      (b_ctrl),
    .cmd_cls_i       (pop_data[SlotW+StW+1 +: ClsW]),
    .cmd_slot_i      (pop_data[StW+1 +: SlotW]),
    .cmd_tag_i       (pop_data[1 +: StW]),
    .cmd_urgent_i    (pop_data[0]),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .picked_tag_o    (picked_tag_o),
    .picked_urgent_o (picked_urgent_o),
    .queue_length_o  (queue_length_o)
  );

  a_fail_no_pick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (picked_tag_o == '0 && !picked_urgent_o))
    else $error("refused item carries pick data");

  a_range_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_RANGE || status_o == ST_EMPTY)) |->
      queue_length_o == '0)
    else $error("non-zero length on range or empty result");

  a_full_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> queue_length_o == 4'(QUEUE_DEPTH))
    else $error("full result with wrong length");

endmodule
